// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check a property on every enabled clock edge
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// check that a condition implies a consequence on the next clock
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)

`endif

`endif

// ===== design/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// ptts_pkg
// Types and constants shared by the periodic task tick scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptts_pkg;

    localparam int MODE_W    = 3;
    localparam int TAG_W     = 8;
    localparam int TIME_W    = 24;
    localparam int CD_W      = TIME_W + 1;
    localparam int PEND_W    = 8;
    localparam int SLOTF_W   = 4;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int TICK_W    = 32;
    localparam int OVR_W     = 16;
    localparam int DISP_MAX  = 16;
    localparam int DISP_CW   = $clog2(DISP_MAX);

    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEL   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DISP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

    localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DUE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [CD_W-1:0]   countdown;
        logic [TIME_W-1:0] period;
        logic [PEND_W-1:0] pending;
    } t_slot_rec;

    localparam int REC_W = $bits(t_slot_rec);

    typedef struct packed {
        logic              load;
        logic              add_write;
        logic              add_full;
        logic              del;
        logic              tick_start;
        logic              tick_rd;
        logic              tick_wb;
        logic              disp_start;
        logic              disp_wb;
        logic              clear;
        logic              idx_inc;
        logic              emit;
        logic [KIND_W-1:0] kind;
    } t_cmd;

    typedef struct packed {
        logic idx_used;
        logic idx_due;
        logic idx_last;
        logic any_due;
        logic disp_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== design/ptts_ram.sv =====
// ----------------------------------------------------------------------------
// ptts_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/ptts_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptts_ctrl
// Controller: decodes each transaction and sequences the slot walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptts_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ptts_pkg::MODE_W-1:0]  i_mode,
    input  ptts_pkg::t_sts               i_sts,
    output ptts_pkg::t_cmd               o_cmd
);

    import ptts_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECODE    = 3'd1;
    localparam logic [2:0] S_ADD       = 3'd2;
    localparam logic [2:0] S_TICK      = 3'd3;
    localparam logic [2:0] S_TICK_END  = 3'd4;
    localparam logic [2:0] S_DISP_SCAN = 3'd5;
    localparam logic [2:0] S_DISP_EMIT = 3'd6;
    localparam logic [2:0] S_EMIT_ONE  = 3'd7;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [MODE_W-1:0] r_mode;
    logic [KIND_W-1:0] r_kind;
    logic [KIND_W-1:0] n_kind;
    logic              w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_mode)
                    MODE_ADD: begin
                        n_state = S_ADD;
                    end
                    MODE_DEL: begin
                        o_cmd.del = 1'b1;
                        n_kind    = KIND_DEL;
                        n_state   = S_EMIT_ONE;
                    end
                    MODE_TICK: begin
                        o_cmd.tick_start = 1'b1;
                        n_state          = S_TICK;
                    end
                    MODE_DISP: begin
                        o_cmd.disp_start = 1'b1;
                        if (i_sts.any_due) begin
                            n_state = S_DISP_SCAN;
                        end else begin
                            n_kind  = KIND_NONE;
                            n_state = S_EMIT_ONE;
                        end
                    end
                    MODE_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_kind      = KIND_CLEAR;
                        n_state     = S_EMIT_ONE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ADD: begin
                n_kind = KIND_ADD;
                priority if (!i_sts.idx_used) begin
                    o_cmd.add_write = 1'b1;
                    n_state         = S_EMIT_ONE;
                end else if (i_sts.idx_last) begin
                    o_cmd.add_full = 1'b1;
                    n_state        = S_EMIT_ONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_TICK: begin
                o_cmd.tick_rd = 1'b1;
                o_cmd.tick_wb = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_TICK_END;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_TICK_END: begin
                o_cmd.tick_wb = 1'b1;
                n_kind        = KIND_TICK;
                n_state       = S_EMIT_ONE;
            end
            S_DISP_SCAN: begin
                priority if (i_sts.idx_due) begin
                    n_state = S_DISP_EMIT;
                end else if (i_sts.idx_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_DISP_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.kind    = KIND_DUE;
                    o_cmd.disp_wb = 1'b1;
                    if (i_sts.disp_last || i_sts.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_DISP_SCAN;
                    end
                end
            end
            S_EMIT_ONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = r_kind;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_ADD;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
        end
    end

endmodule

`default_nettype wire

// ===== design/ptts_dpath.sv =====
// ----------------------------------------------------------------------------
// ptts_dpath
// Datapath: slot table, used and due bits, counters and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptts_dpath #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ptts_pkg::t_cmd                 i_cmd,
    output ptts_pkg::t_sts                 o_sts,
    input  logic [ptts_pkg::TAG_W-1:0]     i_task_tag,
    input  logic [ptts_pkg::TIME_W-1:0]    i_phase,
    input  logic [ptts_pkg::TIME_W-1:0]    i_period,
    input  logic [ptts_pkg::SLOTF_W-1:0]   i_slot,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ptts_pkg::KIND_W-1:0]    o_result_kind,
    output logic [ptts_pkg::SLOTF_W-1:0]   o_slot_index,
    output logic [ptts_pkg::TAG_W-1:0]     o_due_tag,
    output logic [ptts_pkg::STATUS_W-1:0]  o_status,
    output logic [ptts_pkg::TICK_W-1:0]    o_tick_total,
    output logic [ptts_pkg::OVR_W-1:0]     o_overrun_total,
    output logic                           o_last
);

    import ptts_pkg::*;

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(TASK_SLOTS - 1);
    localparam logic signed [OVR_W-1:0] CHK_ONE = OVR_W'(1);

    logic [TASK_SLOTS-1:0] r_used;
    logic [TASK_SLOTS-1:0] r_due;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         r_rd_idx;
    logic                  r_tick_v;
    logic [TAG_W-1:0]      r_tag;
    logic [TIME_W-1:0]     r_phase;
    logic [TIME_W-1:0]     r_period;
    logic [SLOTF_W-1:0]    r_slot;
    logic [SLOTF_W-1:0]    r_res_slot;
    logic [STATUS_W-1:0]   r_status;
    logic [TICK_W-1:0]     r_tick;
    logic signed [OVR_W-1:0] r_ovr_chk;
    logic [OVR_W-1:0]      r_ovr_cnt;
    logic [DISP_CW-1:0]    r_n;

    logic                  r_out_valid;
    logic [KIND_W-1:0]     r_out_kind;
    logic [SLOTF_W-1:0]    r_out_slot;
    logic [TAG_W-1:0]      r_out_tag;
    logic [STATUS_W-1:0]   r_out_status;
    logic [TICK_W-1:0]     r_out_tick;
    logic [OVR_W-1:0]      r_out_ovr;
    logic                  r_out_last;

    logic [REC_W-1:0]      w_rd_bits;
    t_slot_rec             w_rd;
    logic [PEND_W-1:0]     w_pend_eff;
    logic [CD_W-1:0]       w_cd1;
    logic                  w_hit;
    logic [PEND_W-1:0]     w_pend1;
    logic [CD_W-1:0]       w_cd2;
    t_slot_rec             w_tick_rec;
    logic                  w_tick_we;
    logic [PEND_W-1:0]     w_disp_pend;
    logic                  w_disp_free;
    logic                  w_disp_we;
    t_slot_rec             w_add_rec;
    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    t_slot_rec             w_wrec;
    logic [IW+3:0]         w_slot_ext;
    logic [IW-1:0]         w_del_idx;
    logic                  w_del_ok;
    logic [IW+3:0]         w_idx_ext;
    logic [SLOTF_W-1:0]    w_idx4;
    logic [TASK_SLOTS-1:0] w_above;
    logic                  w_disp_last;
    logic                  w_out_free;

    ptts_ram #(
        .WIDTH (REC_W),
        .DEPTH (TASK_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wrec),
        .i_raddr (r_idx),
        .o_rdata (w_rd_bits)
    );

    assign w_rd = t_slot_rec'(w_rd_bits);

    // tick update of the slot read in the previous cycle
    assign w_pend_eff = r_due[r_rd_idx] ? w_rd.pending : '0;
    assign w_cd1      = (w_rd.countdown != '0) ? (w_rd.countdown - 1'b1) : '0;
    assign w_hit      = (w_cd1 == '0);
    assign w_pend1    = (w_hit && (w_pend_eff != '1)) ? (w_pend_eff + 1'b1) : w_pend_eff;
    assign w_cd2      = (w_hit && (w_rd.period != '0)) ? {1'b0, w_rd.period} : w_cd1;
    assign w_tick_rec = '{tag: w_rd.tag, countdown: w_cd2, period: w_rd.period,
                          pending: w_pend1};
    assign w_tick_we  = i_cmd.tick_wb && r_tick_v && r_used[r_rd_idx];

    assign w_disp_pend = w_rd.pending - 1'b1;
    assign w_disp_free = (w_rd.period == '0);
    assign w_disp_we   = i_cmd.disp_wb && !w_disp_free;

    assign w_add_rec = '{tag: r_tag, countdown: {1'b0, r_phase} + 1'b1, period: r_period,
                         pending: '0};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wrec  = w_add_rec;
        priority if (i_cmd.add_write) begin
            w_we = 1'b1;
        end else if (w_tick_we) begin
            w_we    = 1'b1;
            w_waddr = r_rd_idx;
            w_wrec  = w_tick_rec;
        end else if (w_disp_we) begin
            w_we   = 1'b1;
            w_wrec = '{tag: w_rd.tag, countdown: w_rd.countdown, period: w_rd.period,
                       pending: w_disp_pend};
        end else begin
            w_we = 1'b0;
        end
    end

    assign w_slot_ext = {{IW{1'b0}}, r_slot};
    assign w_del_idx  = w_slot_ext[IW-1:0];
    assign w_del_ok   = (w_slot_ext < (IW+4)'(TASK_SLOTS)) && r_used[w_del_idx];

    assign w_idx_ext = {4'b0, r_idx};
    assign w_idx4    = w_idx_ext[SLOTF_W-1:0];

    always_comb begin
        for (int j = 0; j < TASK_SLOTS; j++) begin
            w_above[j] = (IW'(j) > r_idx);
        end
    end

    assign w_disp_last = (r_n == DISP_CW'(DISP_MAX - 1)) || !(|(r_due & w_above));
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign o_sts.idx_used  = r_used[r_idx];
    assign o_sts.idx_due   = r_due[r_idx];
    assign o_sts.idx_last  = (r_idx == IDX_LAST);
    assign o_sts.any_due   = |r_due;
    assign o_sts.disp_last = w_disp_last;
    assign o_sts.out_free  = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_due       <= '0;
            r_idx       <= '0;
            r_tick_v    <= 1'b0;
            r_tick      <= '0;
            r_ovr_chk   <= '0;
            r_ovr_cnt   <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_tick_v <= i_cmd.tick_rd;
            if (i_cmd.load) begin
                r_idx <= '0;
                r_n   <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.disp_wb) begin
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.tick_start) begin
                r_tick <= r_tick + 1'b1;
                if (r_ovr_chk > 0) begin
                    if (r_ovr_cnt != '1) begin
                        r_ovr_cnt <= r_ovr_cnt + 1'b1;
                    end
                end else begin
                    r_ovr_chk <= r_ovr_chk + CHK_ONE;
                end
            end
            if (i_cmd.disp_start) begin
                if (r_ovr_cnt == '0) begin
                    if (r_ovr_chk != {1'b1, {(OVR_W-1){1'b0}}}) begin
                        r_ovr_chk <= r_ovr_chk - CHK_ONE;
                    end
                end else begin
                    r_ovr_cnt <= r_ovr_cnt - 1'b1;
                end
            end
            if (i_cmd.add_write) begin
                r_used[r_idx] <= 1'b1;
                r_due[r_idx]  <= 1'b0;
            end
            if (i_cmd.del && w_del_ok) begin
                r_used[w_del_idx] <= 1'b0;
                r_due[w_del_idx]  <= 1'b0;
            end
            if (w_tick_we) begin
                r_due[r_rd_idx] <= (w_pend1 != '0);
            end
            if (i_cmd.disp_wb) begin
                if (w_disp_free) begin
                    r_used[r_idx] <= 1'b0;
                    r_due[r_idx]  <= 1'b0;
                end else begin
                    r_due[r_idx] <= (w_disp_pend != '0);
                end
            end
            if (i_cmd.clear) begin
                r_due <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (i_cmd.load) begin
            r_tag      <= i_task_tag;
            r_phase    <= i_phase;
            r_period   <= i_period;
            r_slot     <= i_slot;
            r_res_slot <= '0;
            r_status   <= ST_OK;
        end
        if (i_cmd.add_write) begin
            r_res_slot <= w_idx4;
        end
        if (i_cmd.add_full) begin
            r_status <= ST_FULL;
        end
        if (i_cmd.del) begin
            r_res_slot <= r_slot;
            r_status   <= w_del_ok ? ST_OK : ST_EMPTY;
        end
        if (i_cmd.emit) begin
            r_out_kind   <= i_cmd.kind;
            r_out_slot   <= (i_cmd.kind == KIND_DUE) ? w_idx4 : r_res_slot;
            r_out_tag    <= (i_cmd.kind == KIND_DUE) ? w_rd.tag : '0;
            r_out_status <= r_status;
            r_out_tick   <= r_tick;
            r_out_ovr    <= r_ovr_cnt;
            r_out_last   <= (i_cmd.kind == KIND_DUE) ? w_disp_last : 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_slot_index    = r_out_slot;
    assign o_due_tag       = r_out_tag;
    assign o_status        = r_out_status;
    assign o_tick_total    = r_out_tick;
    assign o_overrun_total = r_out_ovr;
    assign o_last          = r_out_last;

endmodule

`default_nettype wire

// ===== design/periodic_task_tick_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_unit
// Time-triggered task table with add, delete, tick, dispatch and clear.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one command transaction:
// i_mode selects add, delete, tick, dispatch or clear pending. Output channel
// (o_out_valid / i_out_ready) returns result transactions; o_last marks the
// final result of a command. Dispatch returns one result per due slot in slot
// order, at most sixteen, or one "nothing due" result.
// One command is in work at a time. Work per command, N = TASK_SLOTS:
//   delete, clear: one result; undefined mode: no result
//   add: a scan for the first free slot, over at most N slots
//   tick: a read-modify-write walk through all N slots of the slot RAM
//   dispatch: one "nothing due" result, else a scan that emits each due slot
// Slot walks run one slot per cycle; a dispatch pauses at each due slot to
// emit its result. Reset clears used and due bits and all counters; slot RAM
// contents are ignored until a slot is added, so no clearing pass is needed.
// A stalled receiver holds the result register; the walk waits at the next
// result and a new command is taken once the current one has finished.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module periodic_task_tick_scheduler_unit #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ptts_pkg::MODE_W-1:0]    i_mode,
    input  logic [ptts_pkg::TAG_W-1:0]     i_task_tag,
    input  logic [ptts_pkg::TIME_W-1:0]    i_phase,
    input  logic [ptts_pkg::TIME_W-1:0]    i_period,
    input  logic [ptts_pkg::SLOTF_W-1:0]   i_slot,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ptts_pkg::KIND_W-1:0]    o_result_kind,
    output logic [ptts_pkg::SLOTF_W-1:0]   o_slot_index,
    output logic [ptts_pkg::TAG_W-1:0]     o_due_tag,
    output logic [ptts_pkg::STATUS_W-1:0]  o_status,
    output logic [ptts_pkg::TICK_W-1:0]    o_tick_total,
    output logic [ptts_pkg::OVR_W-1:0]     o_overrun_total,
    output logic                           o_last
);

    import ptts_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ptts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_mode),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ptts_dpath #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_task_tag      (i_task_tag),
        .i_phase         (i_phase),
        .i_period        (i_period),
        .i_slot          (i_slot),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_slot_index    (o_slot_index),
        .o_due_tag       (o_due_tag),
        .o_status        (o_status),
        .o_tick_total    (o_tick_total),
        .o_overrun_total (o_overrun_total),
        .o_last          (o_last)
    );

    `ASSERT_ALWAYS(a_emit_when_free, i_clk, i_rst_n,
        !w_cmd.emit || w_sts.out_free, "result emitted into a full output register")

    `ASSERT_ALWAYS(a_idle_quiet, i_clk, i_rst_n,
        !o_in_ready || (!w_cmd.emit && !w_cmd.tick_wb && !w_cmd.disp_wb),
        "datapath command while controller idle")

    `ASSERT_ALWAYS(a_disp_emits_due, i_clk, i_rst_n,
        !w_cmd.disp_wb || (w_cmd.emit && (w_cmd.kind == KIND_DUE)),
        "dispatch write-back without a due result")

    `ASSERT_NEXT(a_emit_sets_valid, i_clk, i_rst_n,
        w_cmd.emit, o_out_valid, "emitted result not presented")

endmodule

`default_nettype wire
